@@ hw/rtl/drds_pkg.sv @@
// ----------------------------------------------------------------------------
// drds_pkg
// Shared widths, register indexes and reset values for the distinct random
// draw sorter.
// ----------------------------------------------------------------------------
package drds_pkg;

    // width of a random word and of a drawn value
    localparam int WORD_W      = 16;
    // one more bit so that a full-width range of 2^WORD_W fits
    localparam int RANGE_W     = WORD_W + 1;
    localparam int COUNT_W     = 4;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int CFG_INDEX_W = 2;

    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [RANGE_W-1:0]     range_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t CFG_LOW_BOUND  = 2'd0;
    localparam cfg_index_t CFG_HIGH_BOUND = 2'd1;
    localparam cfg_index_t CFG_DRAW_COUNT = 2'd2;

    // configuration reset values
    localparam word_t  LOW_BOUND_RST  = 16'd1;
    localparam word_t  HIGH_BOUND_RST = 16'd49;
    localparam count_t DRAW_COUNT_RST = 4'd6;

endpackage

@@ hw/rtl/distinct_random_draw_sorter.sv @@
// ----------------------------------------------------------------------------
// distinct_random_draw_sorter
// Draws sets of distinct values in [low_bound, high_bound] from raw random
// words and delivers each completed set in ascending order.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one raw word and its word_valid flag.
// Failed words, biased words and values already in the set are dropped.
// Output channel (out_valid / out_stall): one word per drawn value, ascending,
// is_last high on the final value of a set. Nothing comes out until a set
// reaches its target count.
// Config channel (cfg_valid / cfg_ready): writes low_bound, high_bound and
// draw_count by index; cfg_ready is always high. The user must make writes go
// in while idle; the block itself does not enforce it. Steps per input word,
// with n values held: a failed word or a full set already held goes to the
// target test; a valid word passes the bit-serial remainder, the bias filter,
// a sorted search of up to n values, the insertion shift and the target
// test. A completed set gives one output word per cycle while out_stall is low.
// in_stall is high while a word is in work or a set is being emitted. The
// shared subtract/compare unit forms the remainder one bit per cycle and the
// single read port of the value store sets the search and shift steps.
// A stalled receiver holds the output register and pauses emission.
// Reset (rst_n low) empties the set and loads the default bounds 1..49 and a
// count of 6; the value store itself is not cleared.
// ----------------------------------------------------------------------------
module distinct_random_draw_sorter #(
    parameter int SET_MAX = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration port
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  drds_pkg::cfg_index_t     cfg_index,
    input  drds_pkg::word_t          cfg_data,
    // input words
    input  logic                     in_valid,
    output logic                     in_stall,
    input  drds_pkg::word_t          random_word,
    input  logic                     word_valid,
    // output words
    output logic                     out_valid,
    input  logic                     out_stall,
    output drds_pkg::word_t          drawn_value,
    output logic                     is_last
);
    import drds_pkg::*;

    localparam int CNT_W = $clog2(SET_MAX + 1);
    localparam int IDX_W = (SET_MAX > 1) ? $clog2(SET_MAX) : 1;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        IDLE,
        DIVIDE,
        FILTER,
        SCAN,
        SHIFT,
        TEST,
        EMIT
    } state_t;

    // configuration registers
    word_t  low_bound_reg;
    word_t  high_bound_reg;
    count_t draw_count_reg;

    // sequencer and datapath registers
    state_t                 state_reg,   state_next;
    cnt_t                   count_reg,   count_next;
    cnt_t                   idx_reg,     idx_next;
    cnt_t                   pos_reg,     pos_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    word_t                  rem_reg,     rem_next;
    word_t                  word_reg,    word_next;
    range_t                 range_reg,   range_next;
    word_t                  value_reg,   value_next;
    logic                   out_valid_reg, out_valid_next;
    word_t                  out_value_reg, out_value_next;
    logic                   out_last_reg,  out_last_next;

    // value store, kept in ascending order
    word_t drawn_values [SET_MAX];
    logic  wr_en;
    idx_t  wr_idx;
    word_t wr_data;
    idx_t  rd_idx;
    word_t rd_data_reg;

    // combinational helpers
    word_t          hi_eff;
    range_t         range_comb;
    logic [RANGE_W:0] rem_shift;
    logic           rem_ge;
    range_t         accept_sum;
    logic           accept_word;
    count_t         count_eff;
    range_t         target_wide;
    cnt_t           target;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg  <= LOW_BOUND_RST;
            high_bound_reg <= HIGH_BOUND_RST;
            draw_count_reg <= DRAW_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_BOUND:  low_bound_reg  <= cfg_data;
                CFG_HIGH_BOUND: high_bound_reg <= cfg_data;
                CFG_DRAW_COUNT: draw_count_reg <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // range, inverted bounds act as equal
    assign hi_eff     = (high_bound_reg < low_bound_reg) ? low_bound_reg : high_bound_reg;
    assign range_comb = {1'b0, hi_eff} - {1'b0, low_bound_reg} + RANGE_W'(1);

    // shared restoring step: shift in one word bit, subtract range if it fits
    assign rem_shift = {1'b0, rem_reg, word_reg[bit_idx_reg]};
    assign rem_ge    = rem_shift >= {1'b0, range_reg};

    // unbiased check: word < limit exactly when (word - rem) + range fits the word
    assign accept_sum  = {1'b0, word_reg} - {1'b0, rem_reg} + range_reg;
    assign accept_word = !accept_sum[WORD_W];

    // target count: at least 1, at most SET_MAX and the range
    always_comb
    begin
        count_eff   = (draw_count_reg == '0) ? COUNT_W'(1) : draw_count_reg;
        target_wide = RANGE_W'(count_eff);
        if (target_wide > RANGE_W'(SET_MAX))
            target_wide = RANGE_W'(SET_MAX);
        if (target_wide > range_reg)
            target_wide = range_reg;
        target = target_wide[CNT_W-1:0];
    end

    // single read port of the store, addressed for the next step
    always_comb
    begin
        if (state_next == SHIFT && idx_next != '0)
            rd_idx = idx_t'(idx_next - cnt_t'(1));
        else
            rd_idx = idx_next[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            drawn_values[wr_idx] <= wr_data;
        rd_data_reg <= drawn_values[rd_idx];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        bit_idx_next   = bit_idx_reg;
        rem_next       = rem_reg;
        word_next      = word_reg;
        range_next     = range_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_idx         = idx_reg[IDX_W-1:0];
        wr_data        = rd_data_reg;

        // output word taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = random_word;
                    range_next = range_comb;
                    if (word_valid && count_reg < cnt_t'(SET_MAX))
                    begin
                        rem_next     = '0;
                        bit_idx_next = BIT_IDX_W'(WORD_W - 1);
                        state_next   = DIVIDE;
                    end
                    else
                    begin
                        state_next = TEST;
                    end
                end
            end
            DIVIDE:
            begin
                if (rem_ge)
                    rem_next = WORD_W'(rem_shift - {1'b0, range_reg});
                else
                    rem_next = rem_shift[WORD_W-1:0];
                bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
                if (bit_idx_reg == '0)
                    state_next = FILTER;
            end
            FILTER:
            begin
                if (accept_word)
                begin
                    value_next = low_bound_reg + rem_reg;
                    idx_next   = '0;
                    state_next = SCAN;
                end
                else
                begin
                    state_next = TEST;
                end
            end
            // search the sorted store for a duplicate or the insert point
            SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    pos_next   = idx_reg;
                    state_next = SHIFT;
                end
                else if (rd_data_reg == value_reg)
                begin
                    state_next = TEST;
                end
                else if (rd_data_reg > value_reg)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = SHIFT;
                end
                else
                begin
                    idx_next = idx_reg + cnt_t'(1);
                end
            end
            // move larger values up one place, then drop the new value in
            SHIFT:
            begin
                wr_en = 1'b1;
                if (idx_reg == pos_reg)
                begin
                    wr_data    = value_reg;
                    count_next = count_reg + cnt_t'(1);
                    state_next = TEST;
                end
                else
                begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - cnt_t'(1);
                end
            end
            TEST:
            begin
                if (count_reg >= target)
                begin
                    idx_next   = '0;
                    state_next = EMIT;
                end
                else
                begin
                    state_next = IDLE;
                end
            end
            // stream the set out through the output register
            EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_data_reg;
                    out_last_next  = (idx_reg == count_reg - cnt_t'(1));
                    if (idx_reg == count_reg - cnt_t'(1))
                    begin
                        count_next = '0;
                        state_next = IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + cnt_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            bit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        word_reg      <= word_next;
        range_reg     <= range_next;
        value_reg     <= value_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign in_stall    = (state_reg != IDLE);
    assign out_valid   = out_valid_reg;
    assign drawn_value = out_value_reg;
    assign is_last     = out_last_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a word and did not go busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(SET_MAX))
        else $error("held count above set size");

    a_room_to_insert: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIVIDE |-> count_reg < cnt_t'(SET_MAX))
        else $error("division started with a full store");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == EMIT |-> count_reg != '0)
        else $error("emitting an empty set");

endmodule

@@ test/distinct_random_draw_sorter_tb.sv @@
// ----------------------------------------------------------------------------
// distinct_random_draw_sorter_tb
// Self-checking bench for the distinct random draw sorter. A behavioral
// predictor tracks the bounds, the target count and the values held in the
// current set, and queues the sorted words of each completed set. A monitor
// compares every output word against that queue. Directed tests cover the
// default set, inverted bounds, zero and oversized counts, the full-width
// range and changes of setting in the middle of a set. Output backpressure
// and randomized phases follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module distinct_random_draw_sorter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import drds_pkg::*;

    localparam int SET_MAX       = 8;
    localparam int WORD_MAX      = 65535;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_WORDS   = 24;

    typedef struct packed {
        word_t value;
        logic  last;
    } draw_rec_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    word_t      cfg_data;
    logic       in_valid;
    logic       in_stall;
    word_t      random_word;
    logic       word_valid;
    logic       out_valid;
    logic       out_stall = 1'b0;
    word_t      drawn_value;
    logic       is_last;

    // predictor state
    word_t      cfg_low;
    word_t      cfg_high;
    count_t     cfg_count;
    word_t      held_vals [SET_MAX];
    int         held_n;
    draw_rec_t  pending_draws [$];

    int         mismatches = 0;
    int         idle_cycles = 0;
    int         hold_left = 0;
    bit         hold_request = 1'b0;
    bit         hold_started = 1'b0;
    bit         calm = 1'b0;

    distinct_random_draw_sorter #(
        .SET_MAX (SET_MAX)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .random_word (random_word),
        .word_valid  (word_valid),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drawn_value (drawn_value),
        .is_last     (is_last)
    );

    // clock
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // draw one word into the set and queue the sorted set once it is complete
    task automatic predict_draw(input word_t w, input logic ok);
        word_t       hi;
        word_t       v;
        word_t       order [SET_MAX];
        int unsigned span;
        int unsigned lim;
        int unsigned target;
        int          j;
        bit          dup;
        draw_rec_t   rec;
        hi = (cfg_high < cfg_low) ? cfg_low : cfg_high;
        span = hi - cfg_low + 1;
        target = (cfg_count == 0) ? 1 : cfg_count;
        if (target > SET_MAX)
            target = SET_MAX;
        if (target > span)
            target = span;
        lim = WORD_MAX - (WORD_MAX % span);
        // failed and biased words are dropped, as are values already held
        if (ok && w < lim && held_n < SET_MAX)
        begin
            v = cfg_low + word_t'(w % span);
            dup = 1'b0;
            for (int i = 0; i < held_n; i++)
                if (held_vals[i] == v)
                    dup = 1'b1;
            if (!dup)
            begin
                held_vals[held_n] = v;
                held_n++;
            end
        end
        if (held_n >= target)
        begin
            // ascending insertion sort of the held values
            for (int i = 0; i < held_n; i++)
            begin
                j = i;
                while (j > 0 && order[j-1] > held_vals[i])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = held_vals[i];
            end
            for (int i = 0; i < held_n; i++)
            begin
                rec.value = order[i];
                rec.last = (i == held_n - 1);
                pending_draws.push_back(rec);
            end
            held_n = 0;
        end
    endtask

    // offer one word after a random gap and wait until it is taken
    task automatic send_word(input word_t w, input logic ok);
        while (!calm && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        random_word <= w;
        word_valid  <= ok;
        do
            @(posedge clk);
        while (in_stall);
        predict_draw(w, ok);
    endtask

    task automatic write_reg(input cfg_index_t idx, input word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOW_BOUND:  cfg_low = data;
            CFG_HIGH_BOUND: cfg_high = data;
            CFG_DRAW_COUNT: cfg_count = data[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // stop offering words, drain every expected word, let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly uniform words, now and then the extremes
    function automatic word_t pick_word();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? word_t'(WORD_MAX) : word_t'(0);
        return word_t'($urandom);
    endfunction

    // default bounds 1..49, six values, with every kind of dropped word
    task automatic test_default_set();
        send_word(16'd5, 1'b1);
        send_word(16'hFFFF, 1'b1);  // above the unbiased limit
        send_word(16'd0, 1'b0);     // failed source word
        send_word(16'd0, 1'b1);
        send_word(16'd49, 1'b1);    // maps onto a held value
        send_word(16'd3, 1'b1);
        send_word(16'd1, 1'b1);
        send_word(16'd2, 1'b1);
        send_word(16'd4, 1'b1);     // sixth distinct value closes the set
    endtask

    // high below low collapses the range to one value
    task automatic test_inverted_bounds();
        wait_idle();
        write_reg(CFG_LOW_BOUND, 16'hFFFF);
        write_reg(CFG_HIGH_BOUND, 16'h0000);
        send_word(16'hFFFF, 1'b1);  // limit is the word maximum itself
        send_word(16'd40000, 1'b1);
    endtask

    // a count of zero behaves as one
    task automatic test_zero_count();
        wait_idle();
        write_reg(CFG_LOW_BOUND, 16'd10);
        write_reg(CFG_HIGH_BOUND, 16'd20);
        write_reg(CFG_DRAW_COUNT, 16'd0);
        send_word(16'd21, 1'b1);
    endtask

    // a count above the set size saturates, top of the value range
    task automatic test_oversized_count();
        wait_idle();
        write_reg(CFG_LOW_BOUND, 16'd65528);
        write_reg(CFG_HIGH_BOUND, 16'hFFFF);
        write_reg(CFG_DRAW_COUNT, 16'd15);
        for (int i = 0; i < SET_MAX; i++)
            send_word(word_t'(8 * $urandom_range(8190) + (i * 5 + 7) % 8), 1'b1);
    endtask

    // full-width range has a zero limit, so every word is rejected
    task automatic test_full_width_range();
        wait_idle();
        write_reg(CFG_LOW_BOUND, 16'd0);
        write_reg(CFG_HIGH_BOUND, 16'hFFFF);
        send_word(16'd0, 1'b1);
        send_word(16'hFFFF, 1'b1);
    endtask

    // held values survive new bounds; a lowered target fires on the next word
    task automatic test_midset_config();
        wait_idle();
        write_reg(CFG_HIGH_BOUND, 16'd9);
        write_reg(CFG_DRAW_COUNT, 16'd5);
        send_word(16'd7, 1'b1);
        send_word(16'd2, 1'b1);
        send_word(16'd9, 1'b1);
        wait_idle();
        write_reg(CFG_LOW_BOUND, 16'd100);
        write_reg(CFG_HIGH_BOUND, 16'd105);
        write_reg(CFG_DRAW_COUNT, 16'd4);
        send_word(16'd1, 1'b1);
        send_word(16'd0, 1'b1);
        wait_idle();
        write_reg(CFG_DRAW_COUNT, 16'd1);
        send_word(16'd12345, 1'b0);
    endtask

    // receiver holds off while words keep coming, so the block backs up
    task automatic test_output_backpressure();
        wait_idle();
        write_reg(CFG_LOW_BOUND, 16'd0);
        write_reg(CFG_HIGH_BOUND, 16'd3);
        write_reg(CFG_DRAW_COUNT, 16'd2);
        hold_request = 1'b1;
        repeat (12) send_word(pick_word(), 1'b1);
    endtask

    // random settings per phase, one phase without any idling
    task automatic test_random_sets();
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            span = ($urandom_range(7) == 0) ? $urandom_range(65535, 25)
                                            : $urandom_range(24, 1);
            case ($urandom_range(3))
                0: lo = 0;
                1: lo = 65536 - span;
                default: lo = $urandom_range(65536 - span);
            endcase
            hi = lo + span - 1;
            if ($urandom_range(7) == 0 && lo > 0)
                hi = $urandom_range(lo - 1);
            write_reg(CFG_LOW_BOUND, word_t'(lo));
            write_reg(CFG_HIGH_BOUND, word_t'(hi));
            write_reg(CFG_DRAW_COUNT, word_t'($urandom_range(15)));
            calm = (p == 3);
            repeat (PHASE_WORDS) send_word(pick_word(), $urandom_range(99) < 85);
        end
        calm = 1'b0;
    endtask

    // receiver stall: random, or a long hold when asked
    always @(posedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 38);
    end

    // output monitor
    always @(posedge clk)
    begin
        draw_rec_t exp_rec;
        if (out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
                report_mismatch($sformatf("unexpected word %0d last %0b",
                                          drawn_value, is_last));
            else
            begin
                exp_rec = pending_draws.pop_front();
                if (drawn_value !== exp_rec.value)
                    report_mismatch($sformatf("drawn_value %0d, expected %0d",
                                              drawn_value, exp_rec.value));
                if (is_last !== exp_rec.last)
                    report_mismatch($sformatf("is_last %0b, expected %0b on value %0d",
                                              is_last, exp_rec.last, exp_rec.value));
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_LOW_BOUND;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        random_word <= '0;
        word_valid  <= 1'b0;
        cfg_low   = LOW_BOUND_RST;
        cfg_high  = HIGH_BOUND_RST;
        cfg_count = DRAW_COUNT_RST;
        held_n    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_set();
        test_inverted_bounds();
        test_zero_count();
        test_oversized_count();
        test_full_width_range();
        test_midset_config();
        test_output_backpressure();
        test_random_sets();
        wait_idle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/drds_pkg.sv
hw/rtl/distinct_random_draw_sorter.sv
test/distinct_random_draw_sorter_tb.sv
